// ----- hw/rtl/irenc_pkg.sv -----
// ----------------------------------------------------------------------------
// irenc_pkg
// Shared types, symbol table and letter codes for the Roman numeral encoder.
// ----------------------------------------------------------------------------
package irenc_pkg;

    localparam int NUMBER_W    = 12;
    localparam int LETTER_W    = 7;
    localparam int SYM_IDX_W   = 4;
    localparam int SYM_VALUE_W = 10;
    localparam int NUM_SYMBOLS = 13;

    typedef logic [NUMBER_W-1:0]    t_number;
    typedef logic [LETTER_W-1:0]    t_letter;
    typedef logic [SYM_IDX_W-1:0]   t_sym_idx;
    typedef logic [SYM_VALUE_W-1:0] t_sym_value;

    localparam t_number MAX_NUMBER = 12'd3999;

    // ASCII codes of the numeral letters.
    localparam t_letter LTR_NONE = 7'h00;
    localparam t_letter LTR_C    = 7'h43;
    localparam t_letter LTR_D    = 7'h44;
    localparam t_letter LTR_I    = 7'h49;
    localparam t_letter LTR_L    = 7'h4C;
    localparam t_letter LTR_M    = 7'h4D;
    localparam t_letter LTR_V    = 7'h56;
    localparam t_letter LTR_X    = 7'h58;

    // Write side of the queue between front and back.
    typedef struct packed {
        logic    push;
        t_number number;
    } t_q_wr;

    // Read side of the queue.
    typedef struct packed {
        logic    valid;
        t_number number;
    } t_q_rd;

    // Symbols from largest to smallest value.
    function automatic t_sym_value sym_value(input t_sym_idx k);
        case (k)
            4'd0:    sym_value = 10'd1000;
            4'd1:    sym_value = 10'd900;
            4'd2:    sym_value = 10'd500;
            4'd3:    sym_value = 10'd400;
            4'd4:    sym_value = 10'd100;
            4'd5:    sym_value = 10'd90;
            4'd6:    sym_value = 10'd50;
            4'd7:    sym_value = 10'd40;
            4'd8:    sym_value = 10'd10;
            4'd9:    sym_value = 10'd9;
            4'd10:   sym_value = 10'd5;
            4'd11:   sym_value = 10'd4;
            default: sym_value = 10'd1;
        endcase
    endfunction

    function automatic t_letter sym_first(input t_sym_idx k);
        case (k)
            4'd0:    sym_first = LTR_M;
            4'd1:    sym_first = LTR_C;
            4'd2:    sym_first = LTR_D;
            4'd3:    sym_first = LTR_C;
            4'd4:    sym_first = LTR_C;
            4'd5:    sym_first = LTR_X;
            4'd6:    sym_first = LTR_L;
            4'd7:    sym_first = LTR_X;
            4'd8:    sym_first = LTR_X;
            4'd9:    sym_first = LTR_I;
            4'd10:   sym_first = LTR_V;
            4'd11:   sym_first = LTR_I;
            default: sym_first = LTR_I;
        endcase
    endfunction

    // LTR_NONE marks a symbol with a single letter.
    function automatic t_letter sym_second(input t_sym_idx k);
        case (k)
            4'd1:    sym_second = LTR_M;
            4'd3:    sym_second = LTR_D;
            4'd5:    sym_second = LTR_C;
            4'd7:    sym_second = LTR_L;
            4'd9:    sym_second = LTR_X;
            4'd11:   sym_second = LTR_V;
            default: sym_second = LTR_NONE;
        endcase
    endfunction

endpackage

// ----- hw/rtl/integer_to_roman_encoder.sv -----
// ----------------------------------------------------------------------------
// integer_to_roman_encoder
// Converts numbers from 1 to 3999 into Roman numerals, one ASCII letter a word.
// ----------------------------------------------------------------------------
// Each input word carries a number; values of 0 or above 3999 are taken and
// dropped without output. A valid number becomes a run of words, most
// significant letter first, with tlast set on the final letter. The letter
// generator emits one letter per cycle while the output is not stalled and
// loads the next number from the input queue in a separate step; each letter
// comes from the single greedy symbol search in the back end. Input words are
// taken while the queue of QUEUE_DEPTH numbers has room, independently of
// output back-pressure.
module integer_to_roman_encoder
    import irenc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] number_in, [15:12] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] letter, [7] zero
    output logic        m_axis_tlast    // last_letter
);

    t_q_wr   w_q_wr;
    t_q_rd   w_q_rd;
    logic    w_q_full;
    logic    w_pop;
    t_letter w_letter;

    irenc_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_q_full      (w_q_full),
        .o_q_wr        (w_q_wr)
    );

    irenc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_q_wr),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_rd    (w_q_rd)
    );

    irenc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd       (w_q_rd),
        .o_pop      (w_pop),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_letter   (w_letter),
        .o_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, w_letter};

endmodule

// ----- hw/rtl/irenc_front.sv -----
// ----------------------------------------------------------------------------
// irenc_front
// Accepts input words and passes only numbers from 1 to 3999 to the queue.
// ----------------------------------------------------------------------------
module irenc_front
    import irenc_pkg::*;
(
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] number_in, [15:12] zero
    input  logic        i_q_full,
    output t_q_wr       o_q_wr
);

    t_number w_number;
    logic    w_in_range;

    assign w_number   = s_axis_tdata[NUMBER_W-1:0];
    assign w_in_range = (w_number != '0) && (w_number <= MAX_NUMBER);

    // Words out of range are taken and dropped, since they have no numeral.
    assign s_axis_tready = !i_q_full;

    always_comb begin
        o_q_wr.push   = s_axis_tvalid && !i_q_full && w_in_range;
        o_q_wr.number = w_number;
    end

endmodule

// ----- hw/rtl/irenc_queue.sv -----
// ----------------------------------------------------------------------------
// irenc_queue
// Small first-in first-out buffer of numbers between front and back.
// ----------------------------------------------------------------------------
module irenc_queue
    import irenc_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_q_wr i_wr,
    output logic  o_full,
    input  logic  i_pop,
    output t_q_rd o_rd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_number            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_push;
    logic               w_pop;

    assign o_full = (r_count == CNT_W'(DEPTH));
    assign w_push = i_wr.push && !o_full;
    assign w_pop  = i_pop && (r_count != '0);

    always_comb begin
        o_rd.valid  = (r_count != '0);
        o_rd.number = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr.number;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- hw/rtl/irenc_back.sv -----
// ----------------------------------------------------------------------------
// irenc_back
// Greedy letter generator: one numeral letter per cycle, when not stalled, into an output register.
// ----------------------------------------------------------------------------
module irenc_back
    import irenc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_rd   i_rd,
    output logic    o_pop,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    output t_letter o_letter,
    output logic    o_last
);

    logic     r_busy,     n_busy;
    logic     r_pend,     n_pend;
    logic     r_out_valid, n_out_valid;
    t_number  r_remain,   n_remain;
    t_letter  r_second,   n_second;
    t_letter  r_letter,   n_letter;
    logic     r_last,     n_last;

    t_sym_idx w_sel;
    t_number  w_rem_next;
    logic     w_advance;

    // Largest symbol value not above the remainder; the compares are independent.
    always_comb begin
        w_sel = t_sym_idx'(NUM_SYMBOLS - 1);
        for (int k = NUM_SYMBOLS - 1; k >= 0; k--) begin
            if (r_remain >= {2'b00, sym_value(t_sym_idx'(k))}) begin
                w_sel = t_sym_idx'(k);
            end
        end
    end

    assign w_rem_next = r_remain - {2'b00, sym_value(w_sel)};
    assign w_advance  = !r_out_valid || i_m_tready;

    always_comb begin
        n_busy      = r_busy;
        n_pend      = r_pend;
        n_out_valid = r_out_valid;
        n_remain    = r_remain;
        n_second    = r_second;
        n_letter    = r_letter;
        n_last      = r_last;
        o_pop       = 1'b0;

        if (w_advance) begin
            n_out_valid = 1'b0;
        end

        if (!r_busy) begin
            if (i_rd.valid) begin
                o_pop    = 1'b1;
                n_busy   = 1'b1;
                n_pend   = 1'b0;
                n_remain = i_rd.number;
            end
        end else if (w_advance) begin
            n_out_valid = 1'b1;
            if (r_pend) begin
                // Second letter of a subtractive pair; the value is already taken off.
                n_letter = r_second;
                n_last   = (r_remain == '0);
                n_busy   = (r_remain != '0);
                n_pend   = 1'b0;
            end else begin
                n_letter = sym_first(w_sel);
                n_remain = w_rem_next;
                if (sym_second(w_sel) != LTR_NONE) begin
                    n_pend   = 1'b1;
                    n_second = sym_second(w_sel);
                    n_last   = 1'b0;
                end else begin
                    n_last = (w_rem_next == '0);
                    n_busy = (w_rem_next != '0);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_remain <= n_remain;
        r_second <= n_second;
        r_letter <= n_letter;
        r_last   <= n_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_letter   = r_letter;
    assign o_last     = r_last;

    a_pend_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_busy)
        else $error("pending second letter outside a numeral");

    a_busy_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_pend) |-> (r_remain != '0))
        else $error("busy with nothing left to encode");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_pop)
        else $error("queue popped while a numeral is in progress");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && w_advance && n_last) |=> !r_busy)
        else $error("last letter emitted but numeral still in progress");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the integer to Roman numeral encoder.
// ----------------------------------------------------------------------------
// Numbers are sent into the slave side, and a greedy table walk in the bench
// predicts the letters each one should produce. Every word taken from the
// master side is compared with the oldest predicted letter and its last flag.
// Both sides insert random idle cycles, with some stretches run at full rate.
// ----------------------------------------------------------------------------
module tb_top;
    import irenc_pkg::*;

    typedef struct {
        t_letter letter;
        logic    last;
    } t_letter_word;

    // Greedy symbol table, largest value first.
    localparam int      N_SYM = 13;
    localparam int      SYM_VAL [N_SYM] = '{1000, 900, 500, 400, 100, 90, 50, 40,
                                            10, 9, 5, 4, 1};
    localparam t_letter SYM_HI  [N_SYM] = '{LTR_M, LTR_C, LTR_D, LTR_C, LTR_C,
                                            LTR_X, LTR_L, LTR_X, LTR_X, LTR_I,
                                            LTR_V, LTR_I, LTR_I};
    localparam t_letter SYM_LO  [N_SYM] = '{LTR_NONE, LTR_M, LTR_NONE, LTR_D,
                                            LTR_NONE, LTR_C, LTR_NONE, LTR_L,
                                            LTR_NONE, LTR_X, LTR_NONE, LTR_V,
                                            LTR_NONE};

    // Wait after the last predicted letter, in which any unexpected word is still flagged.
    localparam int SETTLE_CYCLES = 24;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = 16'h0000;   // [11:0] number_in, [15:12] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;              // [6:0] letter, [7] zero
    logic        m_axis_tlast;              // last_letter

    t_letter_word letters_due[$];
    int           n_errors = 0;
    bit           idle_on = 1'b1;

    integer_to_roman_encoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    // Appends the letters of one number's numeral; out-of-range values give none.
    function automatic void encode_numeral(input t_number n);
        t_letter      run[$];
        int           remain;
        int           k;
        t_letter_word w;
        remain = n;
        k = 0;
        if (n == 0 || n > MAX_NUMBER)
            return;
        while (remain != 0) begin
            if (remain >= SYM_VAL[k]) begin
                run.push_back(SYM_HI[k]);
                if (SYM_LO[k] != LTR_NONE)
                    run.push_back(SYM_LO[k]);
                remain -= SYM_VAL[k];
            end else begin
                k++;
            end
        end
        for (int i = 0; i < run.size(); i++) begin
            w.letter = run[i];
            w.last   = (i == run.size() - 1);
            letters_due.push_back(w);
        end
    endfunction

    // Valid is only lowered when a gap follows, so back-to-back words keep it high.
    task automatic send_number(input t_number n);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'h0, n};
        do @(posedge i_clk); while (!s_axis_tready);
        encode_numeral(n);
    endtask

    // Stops sending and waits until every predicted letter has been seen.
    task automatic drain_letters();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (letters_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_range_edges();
        send_number(12'd1);
        send_number(12'd2);
        send_number(12'd3);
        send_number(MAX_NUMBER);
        send_number(12'd3888);
        send_number(12'd3998);
    endtask

    task automatic test_each_symbol();
        for (int k = 0; k < N_SYM; k++)
            send_number(t_number'(SYM_VAL[k]));
    endtask

    // Zero and values above the top of the range are dropped without output.
    task automatic test_rejected_values();
        send_number(12'd0);
        send_number(12'd7);
        send_number(12'd4000);
        send_number(12'hFFF);
        send_number(12'd0);
        send_number(12'd1);
    endtask

    task automatic test_random_numbers();
        for (int blk = 0; blk < 6; blk++) begin
            idle_on = (blk % 3 != 1);
            for (int i = 0; i < 50; i++)
                send_number(t_number'($urandom_range(1, 3999)));
        end
        idle_on = 1'b1;
    endtask

    // Digits 3, 7 and 8 give the longest runs and keep the input queue full.
    task automatic test_long_numerals();
        int digits [4] = '{3, 7, 8, 8};
        int n;
        for (int i = 0; i < 50; i++) begin
            idle_on = (i >= 20);
            n = $urandom_range(0, 3) * 1000;
            n += digits[$urandom_range(0, 3)] * 100;
            n += digits[$urandom_range(0, 3)] * 10;
            n += digits[$urandom_range(0, 3)];
            if (n == 0)
                n = 3888;
            send_number(t_number'(n));
        end
        idle_on = 1'b1;
    endtask

    // Any 12-bit value, so every bit of the field toggles and rejects are mixed in.
    task automatic test_full_field_noise();
        for (int i = 0; i < 60; i++)
            send_number(t_number'($urandom_range(0, 4095)));
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_range_edges();
        test_each_symbol();
        drain_letters();
        test_rejected_values();
        test_random_numbers();
        drain_letters();
        test_long_numerals();
        test_full_field_noise();
        drain_letters();
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Receiver: a random stall before each word, then ready until one is taken.
    initial begin : ready_driver
        int stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = idle_on ? $urandom_range(0, 5) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin
        t_letter_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (letters_due.size() == 0) begin
                $error("unexpected word: letter %h last %b", m_axis_tdata[6:0], m_axis_tlast);
                n_errors++;
            end else begin
                want = letters_due.pop_front();
                if (m_axis_tdata[6:0] !== want.letter) begin
                    $error("letter: expected %h, got %h", want.letter, m_axis_tdata[6:0]);
                    n_errors++;
                end
                if (m_axis_tdata[7] !== 1'b0) begin
                    $error("tdata pad: expected 0, got %b", m_axis_tdata[7]);
                    n_errors++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last_letter: expected %b, got %b", want.last, m_axis_tlast);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/irenc_pkg.sv
hw/rtl/irenc_front.sv
hw/rtl/irenc_queue.sv
hw/rtl/irenc_back.sv
hw/rtl/integer_to_roman_encoder.sv
verif/tb_top.sv
